// ===== hw/rtl/cmrlm_pkg.sv =====
// ----------------------------------------------------------------------------
// cmrlm_pkg
// Shared types and constants of the channel mix and RMS level meter.
// ----------------------------------------------------------------------------
package cmrlm_pkg;

  localparam int SAMPLE_W = 24;
  localparam int VALUE_W  = 27;
  localparam int LEVEL_W  = 16;
  localparam int SQ_W     = 47;
  localparam int CHOUT_W  = 3;
  localparam int CCNT_W   = 4;
  localparam int FRCNT_W  = 13;
  localparam int CFG_W    = 13;

  // configuration register indexes
  localparam logic CFG_CHANNEL_COUNT     = 1'b0;
  localparam logic CFG_FRAMES_PER_BUFFER = 1'b1;

  localparam logic [CCNT_W-1:0]  CHANNEL_COUNT_RST = 4'd2;
  localparam logic [FRCNT_W-1:0] FRAMES_RST        = 13'd256;

  // 20*log10(2) in Q.16, dB offset in Q8.8, ceil(2^21/5)
  localparam logic [18:0]        LOG_SCALE    = 19'd394566;
  localparam logic signed [16:0] LEVEL_OFFSET = 17'sd22179;
  localparam logic [18:0]        RECIP5       = 19'd419431;
  localparam logic signed [19:0] SMOOTH_BIAS  = 20'sd163842;
  localparam logic [16:0]        LEVEL_BIAS   = 17'd32768;
  localparam logic signed [16:0] LEVEL_MIN    = -17'sd32768;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_ACC,
    OP_MIX,
    OP_LREAD,
    OP_DLOAD,
    OP_DSTEP,
    OP_SLOAD,
    OP_SSTEP,
    OP_XLOAD,
    OP_NSTEP,
    OP_LSTEP,
    OP_SCALE,
    OP_SMUL,
    OP_EMIT
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic frame_end;
    logic buf_end;
    logic last_chan;
    logic div_done;
    logic sqrt_done;
    logic root_zero;
    logic norm_done;
    logic log_done;
    logic out_free;
  } stat_t;

endpackage

// ===== hw/rtl/cmrlm_ram.sv =====
// ----------------------------------------------------------------------------
// cmrlm_ram
// Generic single write port RAM with a registered read port.
// ----------------------------------------------------------------------------
module cmrlm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/cmrlm_dp.sv =====
// ----------------------------------------------------------------------------
// cmrlm_dp
// Datapath: config registers, mix, square sums, divider, square root,
// log2, smoothing and the output register.
// ----------------------------------------------------------------------------
module cmrlm_dp #(
  parameter int MAX_CHANNELS = 8,
  parameter int MAX_FRAMES   = 4096
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  cmrlm_pkg::cmd_t                        cmd_i,
  output cmrlm_pkg::stat_t                       stat_o,
  input  logic                                   cfg_we_i,
  input  logic                                   cfg_index_i,
  input  logic [cmrlm_pkg::CFG_W-1:0]            cfg_data_i,
  input  logic signed [cmrlm_pkg::SAMPLE_W-1:0]  sample_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic                                   kind_o,
  output logic [cmrlm_pkg::CHOUT_W-1:0]          channel_o,
  output logic signed [cmrlm_pkg::VALUE_W-1:0]   value_o,
  output logic                                   last_o
);

  localparam int POS_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int FP_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int FR_W  = $clog2(MAX_FRAMES + 1);
  localparam int SUM_W = cmrlm_pkg::SQ_W + FP_W;
  localparam int CCW   = 6;
  localparam int CMPW  = 18;
  localparam int VW    = cmrlm_pkg::VALUE_W;
  localparam int LW    = cmrlm_pkg::LEVEL_W;

  // config
  logic [cmrlm_pkg::CCNT_W-1:0]  chan_cnt_q;
  logic [cmrlm_pkg::FRCNT_W-1:0] frames_q;
  logic [CCW-1:0]                eff_ch;
  logic [CMPW-1:0]               eff_fr;
  logic [FR_W-1:0]               divisor;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_cnt_q <= cmrlm_pkg::CHANNEL_COUNT_RST;
      frames_q   <= cmrlm_pkg::FRAMES_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == cmrlm_pkg::CFG_CHANNEL_COUNT) begin
        chan_cnt_q <= cfg_data_i[cmrlm_pkg::CCNT_W-1:0];
      end else begin
        frames_q <= cfg_data_i[cmrlm_pkg::FRCNT_W-1:0];
      end
    end
  end

  always_comb begin
    if (chan_cnt_q == '0) begin
      eff_ch = CCW'(1);
    end else if (CCW'(chan_cnt_q) > CCW'(MAX_CHANNELS)) begin
      eff_ch = CCW'(MAX_CHANNELS);
    end else begin
      eff_ch = CCW'(chan_cnt_q);
    end
    if (frames_q == '0) begin
      eff_fr = CMPW'(1);
    end else if (CMPW'(frames_q) > CMPW'(MAX_FRAMES)) begin
      eff_fr = CMPW'(MAX_FRAMES);
    end else begin
      eff_fr = CMPW'(frames_q);
    end
  end

  assign divisor = eff_fr[FR_W-1:0];

  // positions and mix
  logic [POS_W-1:0]        chan_pos_q, lc_q;
  logic [FP_W-1:0]         frame_pos_q;
  logic [VW-1:0]           mix_q;
  logic [cmrlm_pkg::SQ_W-1:0] sq_q;
  logic [MAX_CHANNELS-1:0] vld_q;
  logic signed [LW-1:0]    lvl_q [MAX_CHANNELS];
  logic signed [47:0]      sq_full;

  logic frame_end, buf_end, last_chan;
  assign frame_end = (CCW'(chan_pos_q) + CCW'(1)) >= eff_ch;
  assign last_chan = (CCW'(lc_q) + CCW'(1)) >= eff_ch;
  assign buf_end   = (CMPW'(frame_pos_q) + CMPW'(1)) >= eff_fr;
  assign sq_full   = sample_i * sample_i;

  // square sums memory
  logic             ram_we;
  logic [POS_W-1:0] ram_raddr;
  logic [SUM_W-1:0] ram_wdata, ram_rdata;

  assign ram_we    = (cmd_i.op == cmrlm_pkg::OP_ACC);
  assign ram_raddr = (cmd_i.op == cmrlm_pkg::OP_LREAD) ? lc_q : chan_pos_q;
  assign ram_wdata = (vld_q[chan_pos_q] ? ram_rdata : '0) + SUM_W'(sq_q);

  cmrlm_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_CHANNELS),
    .AW    (POS_W)
  ) u_sums (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (chan_pos_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // iterative units
  logic [6:0]       cnt_q;
  logic [SUM_W-1:0] dq_q;
  logic [FR_W-1:0]  rem_q;
  logic [FR_W:0]    dtrial, ddiff;
  logic             dge;
  logic [63:0]      sv_q;
  logic [31:0]      root_q;
  logic [33:0]      srem_q;
  logic [35:0]      strial, sval, sdiff;
  logic             sge;
  logic [31:0]      x_q;
  logic [4:0]       e_q;
  logic [15:0]      frac_q;
  logic [63:0]      xsq;
  logic [32:0]      xy;
  logic [46:0]      ms_clamped;
  logic [39:0]      sprod;
  logic [15:0]      lq;
  logic signed [16:0] new_q, new_lvl;
  logic signed [19:0] ssum;
  logic [37:0]      sm_q;
  logic [16:0]      q5;
  logic [16:0]      lvl17;
  logic signed [LW-1:0] lvl_new, lvl_old;

  assign dtrial = {rem_q, dq_q[SUM_W-1]};
  assign dge    = dtrial >= {1'b0, divisor};
  assign ddiff  = dtrial - {1'b0, divisor};

  assign sval   = {srem_q, sv_q[63:62]};
  assign strial = {2'b00, root_q, 2'b01};
  assign sge    = sval >= strial;
  assign sdiff  = sval - strial;

  assign ms_clamped = (dq_q > SUM_W'(64'd1 << 46)) ? (47'd1 << 46) : dq_q[46:0];

  assign xsq = x_q * x_q;
  assign xy  = xsq[63:31];

  assign sprod   = 40'(cmrlm_pkg::LOG_SCALE) * 40'({e_q, frac_q}) + (40'd1 << 23);
  assign lq      = sprod[39:24];
  assign new_lvl = signed'({1'b0, lq}) - cmrlm_pkg::LEVEL_OFFSET;

  assign lvl_old = lvl_q[lc_q];
  assign ssum    = {{3{new_q[16]}}, new_q} + {{2{lvl_old[15]}}, lvl_old, 2'b00}
                 + cmrlm_pkg::SMOOTH_BIAS;
  assign q5      = sm_q[37:21];
  assign lvl17   = q5 - cmrlm_pkg::LEVEL_BIAS;
  assign lvl_new = signed'(lvl17[LW-1:0]);

  // output register
  logic             out_valid_q, out_kind_q, out_last_q;
  logic [cmrlm_pkg::CHOUT_W-1:0] out_ch_q;
  logic [VW-1:0]    out_val_q;
  logic             out_load;

  assign out_load = (cmd_i.op == cmrlm_pkg::OP_MIX) || (cmd_i.op == cmrlm_pkg::OP_EMIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == cmrlm_pkg::OP_MIX) begin
      out_kind_q <= 1'b0;
      out_ch_q   <= '0;
      out_val_q  <= mix_q;
      out_last_q <= !buf_end;
    end else if (cmd_i.op == cmrlm_pkg::OP_EMIT) begin
      out_kind_q <= 1'b1;
      out_ch_q   <= cmrlm_pkg::CHOUT_W'(lc_q);
      out_val_q  <= {{(VW-LW){lvl_new[LW-1]}}, lvl_new};
      out_last_q <= last_chan;
    end
  end

  // control state of the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_pos_q  <= '0;
      frame_pos_q <= '0;
      lc_q        <= '0;
      mix_q       <= '0;
      vld_q       <= '0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        lvl_q[i] <= '0;
      end
    end else begin
      unique case (cmd_i.op)
        cmrlm_pkg::OP_ACCEPT: begin
          mix_q <= mix_q + {{(VW-cmrlm_pkg::SAMPLE_W){sample_i[cmrlm_pkg::SAMPLE_W-1]}},
                            sample_i};
        end
        cmrlm_pkg::OP_ACC: begin
          vld_q[chan_pos_q] <= 1'b1;
          chan_pos_q <= frame_end ? '0 : chan_pos_q + POS_W'(1);
        end
        cmrlm_pkg::OP_MIX: begin
          mix_q <= '0;
          lc_q  <= '0;
          frame_pos_q <= buf_end ? '0 : frame_pos_q + FP_W'(1);
        end
        cmrlm_pkg::OP_EMIT: begin
          lvl_q[lc_q] <= lvl_new;
          if (last_chan) begin
            vld_q <= '0;
          end else begin
            lc_q <= lc_q + POS_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      unique case (cmd_i.op)
        cmrlm_pkg::OP_DLOAD, cmrlm_pkg::OP_SLOAD, cmrlm_pkg::OP_XLOAD: cnt_q <= '0;
        cmrlm_pkg::OP_DSTEP, cmrlm_pkg::OP_SSTEP, cmrlm_pkg::OP_LSTEP: cnt_q <= cnt_q + 7'd1;
        default: begin
        end
      endcase
    end
  end

  // payload of the level pipeline
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      cmrlm_pkg::OP_ACCEPT: sq_q <= sq_full[cmrlm_pkg::SQ_W-1:0];
      cmrlm_pkg::OP_DLOAD: begin
        dq_q  <= vld_q[lc_q] ? ram_rdata : '0;
        rem_q <= '0;
      end
      cmrlm_pkg::OP_DSTEP: begin
        rem_q <= dge ? ddiff[FR_W-1:0] : dtrial[FR_W-1:0];
        dq_q  <= {dq_q[SUM_W-2:0], dge};
      end
      cmrlm_pkg::OP_SLOAD: begin
        sv_q   <= {1'b0, ms_clamped, 16'd0};
        root_q <= '0;
        srem_q <= '0;
      end
      cmrlm_pkg::OP_SSTEP: begin
        srem_q <= sge ? sdiff[33:0] : sval[33:0];
        root_q <= {root_q[30:0], sge};
        sv_q   <= {sv_q[61:0], 2'b00};
      end
      cmrlm_pkg::OP_XLOAD: begin
        x_q    <= root_q;
        e_q    <= 5'd31;
        frac_q <= '0;
      end
      cmrlm_pkg::OP_NSTEP: begin
        x_q <= {x_q[30:0], 1'b0};
        e_q <= e_q - 5'd1;
      end
      cmrlm_pkg::OP_LSTEP: begin
        // square the mantissa; a carry into bit 32 yields a one bit of the fraction
        x_q    <= xy[32] ? xy[32:1] : xy[31:0];
        frac_q <= {frac_q[14:0], xy[32]};
      end
      cmrlm_pkg::OP_SCALE: new_q <= (root_q == '0) ? cmrlm_pkg::LEVEL_MIN : new_lvl;
      cmrlm_pkg::OP_SMUL:  sm_q  <= ssum[18:0] * cmrlm_pkg::RECIP5;
      default: begin
      end
    endcase
  end

  always_comb begin
    stat_o.frame_end = frame_end;
    stat_o.buf_end   = buf_end;
    stat_o.last_chan = last_chan;
    stat_o.div_done  = (cnt_q == 7'(SUM_W - 1));
    stat_o.sqrt_done = (cnt_q == 7'd31);
    stat_o.root_zero = (root_q == '0);
    stat_o.norm_done = x_q[31];
    stat_o.log_done  = (cnt_q == 7'd15);
    stat_o.out_free  = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = out_kind_q;
  assign channel_o   = out_ch_q;
  assign value_o     = signed'(out_val_q);
  assign last_o      = out_last_q;

endmodule

// ===== hw/rtl/cmrlm_ctrl.sv =====
// ----------------------------------------------------------------------------
// cmrlm_ctrl
// Sequencer: sample update, frame mix output and the per-channel level sweep.
// ----------------------------------------------------------------------------
module cmrlm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  cmrlm_pkg::stat_t stat_i,
  output cmrlm_pkg::cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ACC   = 4'd1;
  localparam logic [3:0] S_MIX   = 4'd2;
  localparam logic [3:0] S_LREAD = 4'd3;
  localparam logic [3:0] S_DLOAD = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_SLOAD = 4'd6;
  localparam logic [3:0] S_SQRT  = 4'd7;
  localparam logic [3:0] S_XLOAD = 4'd8;
  localparam logic [3:0] S_NORM  = 4'd9;
  localparam logic [3:0] S_LOG   = 4'd10;
  localparam logic [3:0] S_SCALE = 4'd11;
  localparam logic [3:0] S_SMUL  = 4'd12;
  localparam logic [3:0] S_EMIT  = 4'd13;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = cmrlm_pkg::OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = cmrlm_pkg::OP_ACCEPT;
          state_d  = S_ACC;
        end
      end
      S_ACC: begin
        cmd_o.op = cmrlm_pkg::OP_ACC;
        state_d  = stat_i.frame_end ? S_MIX : S_IDLE;
      end
      S_MIX: begin
        if (stat_i.out_free) begin
          cmd_o.op = cmrlm_pkg::OP_MIX;
          state_d  = stat_i.buf_end ? S_LREAD : S_IDLE;
        end
      end
      S_LREAD: begin
        cmd_o.op = cmrlm_pkg::OP_LREAD;
        state_d  = S_DLOAD;
      end
      S_DLOAD: begin
        cmd_o.op = cmrlm_pkg::OP_DLOAD;
        state_d  = S_DIV;
      end
      S_DIV: begin
        cmd_o.op = cmrlm_pkg::OP_DSTEP;
        if (stat_i.div_done) state_d = S_SLOAD;
      end
      S_SLOAD: begin
        cmd_o.op = cmrlm_pkg::OP_SLOAD;
        state_d  = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.op = cmrlm_pkg::OP_SSTEP;
        if (stat_i.sqrt_done) state_d = S_XLOAD;
      end
      S_XLOAD: begin
        // silent channel skips the log
        if (stat_i.root_zero) begin
          state_d = S_SCALE;
        end else begin
          cmd_o.op = cmrlm_pkg::OP_XLOAD;
          state_d  = S_NORM;
        end
      end
      S_NORM: begin
        if (stat_i.norm_done) begin
          state_d = S_LOG;
        end else begin
          cmd_o.op = cmrlm_pkg::OP_NSTEP;
        end
      end
      S_LOG: begin
        cmd_o.op = cmrlm_pkg::OP_LSTEP;
        if (stat_i.log_done) state_d = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.op = cmrlm_pkg::OP_SCALE;
        state_d  = S_SMUL;
      end
      S_SMUL: begin
        cmd_o.op = cmrlm_pkg::OP_SMUL;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.op = cmrlm_pkg::OP_EMIT;
          state_d  = stat_i.last_chan ? S_IDLE : S_LREAD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/channel_mix_and_rms_level_meter_top.sv =====
// ----------------------------------------------------------------------------
// channel_mix_and_rms_level_meter_top
// Interleaved audio mixer with smoothed per-channel RMS levels in dB.
// ----------------------------------------------------------------------------
// A sample is accepted, then its channel's sum of squares is updated by a
// read-modify-write in a small RAM; the last sample of a frame then also
// loads the mono mix into the output register once that register is free.
// At the end of a buffer each channel runs through the bit-serial divider,
// the bit-pair square root, the mantissa normalizing shift and the 16
// squaring steps of the log2 unit, then scaling, smoothing and output.
// Input is stalled during that sweep. Results wait in a one-entry output
// register.
// ----------------------------------------------------------------------------
module channel_mix_and_rms_level_meter_top #(
  parameter int MAX_CHANNELS = 8,
  parameter int MAX_FRAMES   = 4096
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic                                   cfg_index_i,
  input  logic [cmrlm_pkg::CFG_W-1:0]            cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [cmrlm_pkg::SAMPLE_W-1:0]  sample_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic                                   kind_o,
  output logic [cmrlm_pkg::CHOUT_W-1:0]          channel_o,
  output logic signed [cmrlm_pkg::VALUE_W-1:0]   value_o,
  output logic                                   last_o
);

  cmrlm_pkg::cmd_t  cmd;
  cmrlm_pkg::stat_t stat;

  cmrlm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  cmrlm_dp #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_FRAMES   (MAX_FRAMES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .channel_o   (channel_o),
    .value_o     (value_o),
    .last_o      (last_o)
  );

`ifndef ASSERT_OFF
  // every accepted sample needs its sum update before the next one
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("sample accepted back to back");

  a_mix_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !kind_o) |-> (channel_o == '0))
    else $error("mix result with nonzero channel");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o) |-> (value_o[26:15] == {12{value_o[15]}}))
    else $error("level not a sign-extended 16-bit value");
`endif

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the channel mix and RMS level meter: a directed
// table, then random buffers under several settings, with random idling on
// both sides and checking of every output transaction against a predictor.
// ----------------------------------------------------------------------------
module tb;

  typedef struct {
    logic        kind;
    logic [2:0]  chan;
    logic [26:0] value;
    logic        last;
  } meter_res_t;

  typedef struct {
    bit   is_cfg;
    logic idx;
    int   data;
    bit   chk;
    int   exp_mix;
  } row_t;

  logic                                  clk_i = 1'b0;
  logic                                  rst_ni = 1'b0;
  logic                                  cfg_we_i = 1'b0;
  logic                                  cfg_index_i = 1'b0;
  logic [cmrlm_pkg::CFG_W-1:0]           cfg_data_i = '0;
  logic                                  in_valid_i = 1'b0;
  logic                                  in_stall_o;
  logic signed [cmrlm_pkg::SAMPLE_W-1:0] sample_i = '0;
  logic                                  out_valid_o;
  logic                                  out_stall_i = 1'b0;
  logic                                  kind_o;
  logic [cmrlm_pkg::CHOUT_W-1:0]         channel_o;
  logic signed [cmrlm_pkg::VALUE_W-1:0]  value_o;
  logic                                  last_o;

  channel_mix_and_rms_level_meter_top u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .sample_i,
    .out_valid_o, .out_stall_i, .kind_o, .channel_o, .value_o, .last_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [3:0]        chan_reg;
  logic [12:0]       frame_reg;
  int                chan_pos, frame_pos;
  logic [26:0]       mix_acc;
  longint unsigned   sq_sum [8];
  int                level [8];

  meter_res_t        pending_q [$];
  int                errors = 0;
  int                n_samples = 0;
  int                n_results = 0;
  int                n_levels = 0;
  bit                calm = 1'b0;
  int                hold_req = 0;

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, t;
    res = 0;
    for (int b = 31; b >= 0; b--) begin
      t = res | (64'd1 << b);
      if (t * t <= v) res = t;
    end
    return res;
  endfunction

  function automatic longint unsigned log2_fix(longint unsigned r);
    int              e;
    longint unsigned x, frac;
    e = 0;
    frac = 0;
    while (e < 31 && (r >> (e + 1)) != 0) e++;
    x = r << (31 - e);
    for (int i = 0; i < 16; i++) begin
      x = (x * x) >> 31;
      frac = frac << 1;
      if (x >= (64'd1 << 32)) begin
        x = x >> 1;
        frac = frac | 1;
      end
    end
    return (longint'(e) << 16) + frac;
  endfunction

  function automatic int fresh_db(longint unsigned sum, int frames);
    longint unsigned ms, r, q;
    ms = sum / longint'(frames);
    if (ms > (64'd1 << 46)) ms = 64'd1 << 46;
    r = root_floor(ms << 16);
    if (r == 0) return -32768;
    q = (longint'(cmrlm_pkg::LOG_SCALE) * log2_fix(r) + (64'd1 << 23)) >> 24;
    return int'(q) - int'(cmrlm_pkg::LEVEL_OFFSET);
  endfunction

  function automatic int used_chans();
    if (chan_reg == 0) return 1;
    if (chan_reg > 8) return 8;
    return int'(chan_reg);
  endfunction

  function automatic int used_frames();
    if (frame_reg == 0) return 1;
    if (frame_reg > 4096) return 4096;
    return int'(frame_reg);
  endfunction

  // queue the results that one accepted sample causes
  function automatic void predict_sample(int s, bit chk, int exp_mix);
    int         chans, frames, pos, lv;
    bit         buf_end;
    meter_res_t r;
    chans = used_chans();
    frames = used_frames();
    pos = (chan_pos >= 8) ? 7 : chan_pos;
    sq_sum[pos] += longint'(s) * longint'(s);
    mix_acc = mix_acc + 27'(s);
    if (pos + 1 < chans) begin
      chan_pos = pos + 1;
      return;
    end
    chan_pos = 0;
    buf_end = (frame_pos + 1 >= frames);
    r.kind = 1'b0;
    r.chan = '0;
    r.value = chk ? 27'(exp_mix) : mix_acc;
    r.last = !buf_end;
    pending_q = {pending_q, r};
    mix_acc = '0;
    if (!buf_end) begin
      frame_pos++;
      return;
    end
    frame_pos = 0;
    for (int c = 0; c < chans; c++) begin
      lv = (fresh_db(sq_sum[c], frames) + 4 * level[c] + 2 + 5 * 32768) / 5 - 32768;
      level[c] = lv;
      r.kind = 1'b1;
      r.chan = 3'(c);
      r.value = 27'(lv);
      r.last = (c + 1 == chans);
      pending_q = {pending_q, r};
    end
    for (int c = 0; c < 8; c++) sq_sum[c] = 0;
  endfunction

  task automatic send_sample(int s, bit chk = 1'b0, int exp_mix = 0);
    if (!calm) begin
      while ($urandom_range(99) < 25) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    sample_i <= cmrlm_pkg::SAMPLE_W'(s);
    do @(posedge clk_i); while (in_stall_o);
    predict_sample(s, chk, exp_mix);
    n_samples++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    // samples that end no frame are still in the sum-of-squares update
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, int data);
    drain();
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= cmrlm_pkg::CFG_W'(data);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == cmrlm_pkg::CFG_CHANNEL_COUNT) chan_reg = 4'(data);
    else frame_reg = 13'(data);
  endtask

  function automatic int rand_sample();
    case ($urandom_range(7))
      0: return 8388607;
      1: return -8388608;
      2: return 0;
      3: return $urandom_range(200) - 100;
      default: return int'($signed(24'($urandom)));
    endcase
  endfunction

  // receiver: random stall plus long hold-off on request
  int hold_seen = 0;
  int hold_left = 0;
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 400;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < 25);
    end
  end

  // output checker
  always @(posedge clk_i) begin
    meter_res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (kind_o) n_levels++;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected transaction kind=%0d ch=%0d value=%0d last=%0d",
                 $time, kind_o, channel_o, value_o, last_o);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (kind_o !== e.kind || channel_o !== e.chan || value_o !== e.value ||
            last_o !== e.last) begin
          $display("%0t: mismatch expected kind=%0d ch=%0d value=%0d last=%0d",
                   $time, e.kind, e.chan, $signed(e.value), e.last);
          $display("%0t:          actual   kind=%0d ch=%0d value=%0d last=%0d",
                   $time, kind_o, channel_o, value_o, last_o);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("%0t: timeout", $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  row_t dir_rows [] = '{
    '{0, 0, 100, 0, 0}, '{0, 0, -100, 1, 0},
    '{1, cmrlm_pkg::CFG_CHANNEL_COUNT, 1, 0, 0},
    '{1, cmrlm_pkg::CFG_FRAMES_PER_BUFFER, 1, 0, 0},
    '{0, 0, 8388607, 1, 8388607}, '{0, 0, -8388608, 1, -8388608}, '{0, 0, 0, 1, 0},
    '{1, cmrlm_pkg::CFG_CHANNEL_COUNT, 0, 0, 0}, '{0, 0, 5, 1, 5},
    '{1, cmrlm_pkg::CFG_CHANNEL_COUNT, 15, 0, 0},
    '{0, 0, -8388608, 0, 0}, '{0, 0, -8388608, 0, 0}, '{0, 0, -8388608, 0, 0},
    '{0, 0, -8388608, 0, 0}, '{0, 0, -8388608, 0, 0}, '{0, 0, -8388608, 0, 0},
    '{0, 0, -8388608, 0, 0}, '{0, 0, -8388608, 1, -67108864},
    '{1, cmrlm_pkg::CFG_FRAMES_PER_BUFFER, 0, 0, 0},
    '{1, cmrlm_pkg::CFG_CHANNEL_COUNT, 3, 0, 0},
    '{0, 0, 1, 0, 0}, '{0, 0, 2, 0, 0}, '{0, 0, 3, 1, 6},
    '{1, cmrlm_pkg::CFG_FRAMES_PER_BUFFER, 8191, 0, 0},
    '{1, cmrlm_pkg::CFG_CHANNEL_COUNT, 1, 0, 0},
    '{0, 0, 7, 1, 7}, '{0, 0, 7, 1, 7}, '{0, 0, 7, 1, 7}, '{0, 0, 7, 1, 7},
    // buffer position now beyond the new end
    '{1, cmrlm_pkg::CFG_FRAMES_PER_BUFFER, 2, 0, 0}, '{0, 0, 9, 1, 9}
  };

  initial begin
    int phase, sent, ch, fr;
    chan_reg = cmrlm_pkg::CHANNEL_COUNT_RST;
    frame_reg = cmrlm_pkg::FRAMES_RST;
    chan_pos = 0;
    frame_pos = 0;
    mix_acc = '0;
    for (int c = 0; c < 8; c++) begin
      sq_sum[c] = 0;
      level[c] = 0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_reg(dir_rows[i].idx, dir_rows[i].data);
      else send_sample(dir_rows[i].data, dir_rows[i].chk, dir_rows[i].exp_mix);
    end

    sent = 0;
    phase = 0;
    while (sent < 180) begin
      case (phase)
        0: begin ch = 2; fr = 3; end
        1: begin ch = 1; fr = 1; end
        2: begin ch = 8; fr = 2; end
        3: begin ch = 15; fr = 1; end
        default: begin ch = $urandom_range(1, 8); fr = $urandom_range(1, 5); end
      endcase
      write_reg(cmrlm_pkg::CFG_CHANNEL_COUNT, ch);
      write_reg(cmrlm_pkg::CFG_FRAMES_PER_BUFFER, fr);
      calm = (phase == 2);
      // output held off while one-sample buffers keep arriving
      if (phase == 1) hold_req++;
      for (int k = 0; k < 30; k++) send_sample(rand_sample());
      sent += 30;
      phase++;
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("Covered %0d samples, %0d output transactions (%0d levels) over %0d phases.",
             n_samples, n_results, n_levels, phase);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
